[rtl/ipt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipt_pkg
// Shared constants, codes and types of the inverted page table replacer.
// ----------------------------------------------------------------------------
package ipt_pkg;

  localparam int FRAMES       = 64;
  localparam int PROCS        = 16;
  localparam int OFFSET_WIDTH = 12;

  localparam int FIDX_W = $clog2(FRAMES);
  localparam int FCNT_W = $clog2(FRAMES + 1);
  localparam int PIDX_W = $clog2(PROCS);
  localparam int PCNT_W = $clog2(PROCS + 1);
  localparam int PID_W  = 16;
  localparam int ADDR_W = 32;
  localparam int PAGE_W = ADDR_W - OFFSET_WIDTH;
  localparam int TAG_W  = PID_W + PAGE_W;
  localparam int FREQ_W = 16;
  localparam int PICK_W = 6;
  localparam int FRAME_W = 6;
  localparam int CNT_W  = 32;

  localparam logic [15:0] DECAY_RESET = 16'd1000;
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  localparam logic [1:0] POL_CLOCK  = 2'd0;
  localparam logic [1:0] POL_LFU    = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_DECAY  = 1'b1;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_TERM   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECAY,
    ST_LOOKUP,
    ST_HIT_SCAN,
    ST_SELECT,
    ST_CLK_SCAN,
    ST_CLK_FIN,
    ST_LFU_SCAN,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_TERM_SCAN,
    ST_DONE
  } ipt_state_t;

endpackage

[rtl/inverted_page_table_replacer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverted_page_table_replacer_unit
// Inverted page table with clock class, least frequent and random victim
// choice, walked one frame per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// a denied beat walks no frames; a hit ends its tag walk at the matching frame,
//   a miss may add a clock or least frequent victim walk after the tag walk, and
//   a decay period end adds a frequency halving walk before the lookup
// terminate takes one tag walk; one item at a time, the next beat
//   is taken only after the result beat is accepted
// reset (synchronous, active low) clears marks, counts and the active list at
//   once; frequencies read as one until first written, so no clearing pass
module inverted_page_table_replacer_unit
  import ipt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // proc_id, address, is_write, random_pick
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // granted, hit, frame, fault_kind,
                                  // read_fault_total, write_fault_total
);

  ipt_state_t state_r, state_nxt;

  logic [1:0]        policy_r;
  logic [15:0]       period_r;
  logic              act_r;
  logic [PID_W-1:0]  pid_r;
  logic [PAGE_W-1:0] page_r;
  logic              wr_r;
  logic [PICK_W-1:0] pick_r;
  logic [15:0]       tally_r;
  logic [CNT_W-1:0]  rf_r, wf_r;
  logic [FIDX_W-1:0] scan_start_r;

  logic [FRAMES-1:0] occ_r, val_r, dirty_r, ref_r, fv_r;
  logic [PID_W-1:0]  ap_r [PROCS];
  logic [PCNT_W-1:0] acnt_r;

  logic [FCNT_W-1:0] iss_r;
  logic              pend_vld_r;
  logic [FIDX_W-1:0] pend_idx_r;

  logic [FIDX_W-1:0] victim_r;
  logic              hit_r, bump2_r, granted_r;
  logic [1:0]        kind_r;
  logic [3:0]        cf_r;
  logic [FIDX_W-1:0] cidx_r [4];
  logic [FREQ_W-1:0] bestf_r;

  logic              out_tvalid_r;
  logic [79:0]       out_tdata_r;

  // ram ports
  logic              tag_we, freq_we;
  logic [FIDX_W-1:0] tag_raddr, freq_raddr, freq_waddr;
  logic [TAG_W-1:0]  tag_rdata;
  logic [FREQ_W-1:0] freq_rdata, freq_wdata;

  ipt_ram #(.W(TAG_W), .D(FRAMES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (victim_r),
    .wdata ({pid_r, page_r}),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  ipt_ram #(.W(FREQ_W), .D(FRAMES)) u_freq_ram (
    .clk   (clk),
    .we    (freq_we),
    .waddr (freq_waddr),
    .wdata (freq_wdata),
    .raddr (freq_raddr),
    .rdata (freq_rdata)
  );

  // combinational helpers
  logic              in_acc;
  logic [15:0]       tally_inc;
  logic [FREQ_W-1:0] freq_cur, freq_vic;
  logic [FREQ_W:0]   freq_sum;
  logic              tag_pid_eq, hit_now, scan_last;
  logic [PROCS-1:0]  pmatch;
  logic              is_act;
  logic [PCNT_W-1:0] pfirst;
  logic [FIDX_W:0]   csum;
  logic [FIDX_W-1:0] cidx;
  logic [1:0]        ccls;
  logic [3:0]        cls_upto;
  logic              clk_take;
  logic [FIDX_W-1:0] clk_victim;
  logic [FRAMES-1:0] ref_clr;

  assign in_acc    = in_tvalid && in_tready;
  assign tally_inc = tally_r + 16'd1;
  assign tag_raddr = iss_r[FIDX_W-1:0];
  assign freq_raddr = (state_r == ST_FILL_RD) ? victim_r : iss_r[FIDX_W-1:0];
  assign freq_waddr = (state_r == ST_DECAY) ? pend_idx_r : victim_r;

  assign freq_cur = fv_r[pend_idx_r] ? freq_rdata : FREQ_W'(1);
  assign freq_vic = fv_r[victim_r] ? freq_rdata : FREQ_W'(1);
  assign freq_sum = {1'b0, freq_vic} + (bump2_r ? (FREQ_W+1)'(2) : (FREQ_W+1)'(1));

  always_comb begin
    if (state_r == ST_DECAY) begin
      freq_wdata = freq_cur >> 1;
    end else begin
      freq_wdata = freq_sum[FREQ_W] ? FREQ_MAX : freq_sum[FREQ_W-1:0];
    end
  end

  assign tag_pid_eq = occ_r[pend_idx_r] && (tag_rdata[TAG_W-1:PAGE_W] == pid_r);
  assign hit_now    = pend_vld_r && tag_pid_eq && (tag_rdata[PAGE_W-1:0] == page_r);
  assign scan_last  = pend_vld_r && (pend_idx_r == FIDX_W'(FRAMES - 1));

  always_comb begin
    pfirst = '0;
    for (int i = PROCS - 1; i >= 0; i--) begin
      pmatch[i] = (PCNT_W'(i) < acnt_r) && (ap_r[i] == pid_r);
      if (pmatch[i]) begin
        pfirst = PCNT_W'(i);
      end
    end
  end
  assign is_act = |pmatch;

  assign csum = {1'b0, scan_start_r} + (FIDX_W+1)'(iss_r);
  assign cidx = (csum >= (FIDX_W+1)'(FRAMES)) ? FIDX_W'(csum - (FIDX_W+1)'(FRAMES))
                                               : csum[FIDX_W-1:0];
  assign ccls = {ref_r[cidx], dirty_r[cidx]};

  // classes up to and including the one of the frame under the scan
  always_comb begin
    unique case (ccls)
      2'd0:    cls_upto = 4'b0001;
      2'd1:    cls_upto = 4'b0011;
      2'd2:    cls_upto = 4'b0111;
      default: cls_upto = 4'b1111;
    endcase
  end
  assign clk_take = ((cf_r & cls_upto) == 4'b0000);

  always_comb begin
    if (cf_r[0]) begin
      clk_victim = cidx_r[0];
    end else if (cf_r[1]) begin
      clk_victim = cidx_r[1];
    end else if (cf_r[2]) begin
      clk_victim = cidx_r[2];
    end else begin
      clk_victim = cidx_r[3];
    end
  end

  // reference marks from the scan start up to the frame before the victim
  always_comb begin
    for (int k = 0; k < FRAMES; k++) begin
      if (scan_start_r <= victim_r) begin
        ref_clr[k] = (FIDX_W'(k) >= scan_start_r) && (FIDX_W'(k) < victim_r);
      end else begin
        ref_clr[k] = (FIDX_W'(k) >= scan_start_r) || (FIDX_W'(k) < victim_r);
      end
    end
  end

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    tag_we    = 1'b0;
    freq_we   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == ACT_ACCESS && tally_inc >= period_r) begin
            state_nxt = ST_DECAY;
          end else begin
            state_nxt = ST_LOOKUP;
          end
        end
      end
      ST_DECAY: begin
        freq_we = pend_vld_r;
        if (scan_last) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (act_r == ACT_TERM) begin
          state_nxt = ST_TERM_SCAN;
        end else if (is_act) begin
          state_nxt = ST_HIT_SCAN;
        end else if (acnt_r < PCNT_W'(PROCS)) begin
          state_nxt = ST_SELECT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_HIT_SCAN: begin
        if (hit_now) begin
          state_nxt = ST_FILL_RD;
        end else if (scan_last) begin
          state_nxt = ST_SELECT;
        end
      end
      ST_SELECT: begin
        unique case (policy_r)
          POL_CLOCK:  state_nxt = ST_CLK_SCAN;
          POL_LFU:    state_nxt = ST_LFU_SCAN;
          POL_RANDOM: state_nxt = ST_FILL_RD;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_CLK_SCAN: begin
        if (iss_r == FCNT_W'(FRAMES - 1)) begin
          state_nxt = ST_CLK_FIN;
        end
      end
      ST_CLK_FIN:  state_nxt = ST_FILL_RD;
      ST_LFU_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_FILL_RD;
        end
      end
      ST_FILL_RD:  state_nxt = ST_FILL_WR;
      ST_FILL_WR: begin
        tag_we    = 1'b1;
        freq_we   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_TERM_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      policy_r     <= POL_CLOCK;
      period_r     <= DECAY_RESET;
      tally_r      <= '0;
      rf_r         <= '0;
      wf_r         <= '0;
      scan_start_r <= '0;
      occ_r        <= '0;
      val_r        <= '0;
      dirty_r      <= '0;
      ref_r        <= '0;
      fv_r         <= '0;
      acnt_r       <= '0;
      iss_r        <= '0;
      pend_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_POLICY: policy_r <= cfg_wdata[1:0];
          REG_DECAY:  period_r <= cfg_wdata;
          default:    ;
        endcase
      end

      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      // frame walk: issue one read a cycle; the data lands in the next cycle
      if (state_nxt != state_r) begin
        iss_r      <= '0;
        pend_vld_r <= 1'b0;
      end else if (state_r == ST_CLK_SCAN) begin
        iss_r <= iss_r + FCNT_W'(1);
      end else if (iss_r < FCNT_W'(FRAMES)) begin
        iss_r      <= iss_r + FCNT_W'(1);
        pend_vld_r <= 1'b1;
        pend_idx_r <= iss_r[FIDX_W-1:0];
      end else begin
        pend_vld_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            act_r     <= in_tuser;
            pid_r     <= in_tdata[15:0];
            page_r    <= in_tdata[47:16+OFFSET_WIDTH];
            wr_r      <= in_tdata[48];
            pick_r    <= in_tdata[54:49];
            hit_r     <= 1'b0;
            bump2_r   <= 1'b0;
            granted_r <= 1'b0;
            kind_r    <= KIND_NONE;
            victim_r  <= '0;
            cf_r      <= '0;
            if (in_tuser == ACT_ACCESS) begin
              tally_r <= (tally_inc >= period_r) ? 16'd0 : tally_inc;
            end
          end
        end
        ST_DECAY: begin
          if (pend_vld_r) begin
            fv_r[pend_idx_r] <= 1'b1;
          end
        end
        ST_LOOKUP: begin
          if (act_r == ACT_TERM) begin
            if (is_act) begin
              for (int i = 0; i < PROCS - 1; i++) begin
                if (PCNT_W'(i) >= pfirst && PCNT_W'(i + 1) < acnt_r) begin
                  ap_r[i] <= ap_r[i+1];
                end
              end
              acnt_r <= acnt_r - PCNT_W'(1);
            end
          end else if (!is_act && acnt_r < PCNT_W'(PROCS)) begin
            ap_r[acnt_r[PIDX_W-1:0]] <= pid_r;
            acnt_r <= acnt_r + PCNT_W'(1);
          end
        end
        ST_HIT_SCAN: begin
          if (hit_now) begin
            hit_r    <= 1'b1;
            victim_r <= pend_idx_r;
          end
        end
        ST_SELECT: begin
          victim_r <= FIDX_W'(pick_r % FRAMES);
        end
        ST_CLK_SCAN: begin
          if (!cf_r[ccls]) begin
            cf_r[ccls]   <= 1'b1;
            cidx_r[ccls] <= cidx;
          end
          // the last frame counts too before the class table settles
          if (state_nxt == ST_CLK_FIN) begin
            victim_r <= clk_take ? cidx : clk_victim;
          end
        end
        ST_CLK_FIN: begin
          ref_r        <= ref_r & ~ref_clr;
          scan_start_r <= (victim_r == FIDX_W'(FRAMES - 1)) ? '0
                                                            : victim_r + FIDX_W'(1);
        end
        ST_LFU_SCAN: begin
          if (pend_vld_r && (pend_idx_r == '0 || freq_cur < bestf_r)) begin
            bestf_r  <= freq_cur;
            victim_r <= pend_idx_r;
          end
          bump2_r <= 1'b1;
        end
        ST_FILL_RD: begin
          granted_r <= 1'b1;
          if (!hit_r) begin
            if (dirty_r[victim_r]) begin
              kind_r <= KIND_WRITE;
              if (wf_r != CNT_MAX) begin
                wf_r <= wf_r + CNT_W'(1);
              end
            end else begin
              kind_r <= KIND_READ;
              if (rf_r != CNT_MAX) begin
                rf_r <= rf_r + CNT_W'(1);
              end
            end
          end
        end
        ST_FILL_WR: begin
          occ_r[victim_r]   <= 1'b1;
          ref_r[victim_r]   <= 1'b1;
          dirty_r[victim_r] <= wr_r;
          val_r[victim_r]   <= 1'b1;
          fv_r[victim_r]    <= 1'b1;
        end
        ST_TERM_SCAN: begin
          if (pend_vld_r && tag_pid_eq) begin
            val_r[pend_idx_r] <= 1'b0;
          end
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {6'd0, wf_r, rf_r, kind_r, FRAME_W'(victim_r) &
                             {FRAME_W{granted_r}}, hit_r, granted_r};
          end
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE) && !out_tvalid_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // no new beat while a result still waits
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input ready while result pending");

  a_busy_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("ready during item");

  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1]) |-> (out_tdata[0] && out_tdata[9:8] == KIND_NONE))
    else $error("hit with fault");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acnt_r <= PCNT_W'(PROCS)) else $error("active list overflow");

endmodule

[rtl/ipt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipt_ram #(
  parameter int W = 16,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[dv/tb_inverted_page_table_replacer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inverted_page_table_replacer_unit
// Drives access and terminate beats into the page table under each victim
// policy and several decay periods. Every result beat is checked field by
// field against a behavioural page table kept alongside, or against the
// typed fields of a directed row, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_inverted_page_table_replacer_unit;
  import ipt_pkg::*;

  typedef struct packed {
    logic        act;
    logic [15:0] pid;
    logic [31:0] addr;
    logic        wr;
    logic [5:0]  pick;
  } req_t;

  // lowest field last, so the layout follows out_tdata
  typedef struct packed {
    logic [31:0] wr_total;
    logic [31:0] rd_total;
    logic [1:0]  kind;
    logic [5:0]  frame;
    logic        hit;
    logic        granted;
  } resp_t;

  typedef struct {
    req_t        rq;
    bit          typed;
    logic        granted;
    logic        hit;
    logic [5:0]  frame;
    logic [1:0]  kind;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  inverted_page_table_replacer_unit u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // page table shadow
  logic [15:0] pt_proc [FRAMES];
  logic [19:0] pt_page [FRAMES];
  bit          pt_occ [FRAMES];
  bit          pt_valid [FRAMES];
  bit          pt_dirty [FRAMES];
  bit          pt_ref [FRAMES];
  logic [15:0] pt_freq [FRAMES];
  logic [15:0] live_pids [PROCS];
  int          live_cnt;
  int          hand;
  logic [15:0] tally;
  logic [31:0] rd_faults, wr_faults;
  logic [1:0]  cur_policy;
  logic [15:0] cur_decay;

  resp_t       pending_q [$];
  int          errors = 0;
  int          n_items = 0, n_hits = 0, n_faults = 0, n_denied = 0;
  int          idle_mode = 0;

  function automatic void freq_bump(int f);
    if (pt_freq[f] != 16'hFFFF) pt_freq[f]++;
  endfunction

  function automatic void fill_frame(int f, logic [15:0] pid, logic [19:0] pg, bit wr);
    pt_proc[f] = pid;
    pt_page[f] = pg;
    pt_occ[f] = 1;
    pt_ref[f] = 1;
    freq_bump(f);
    pt_dirty[f] = wr;
    pt_valid[f] = 1;
  endfunction

  function automatic int clock_pick();
    int idx, k, cls;
    bit found;
    idx = 0;
    found = 0;
    for (cls = 0; cls < 4 && !found; cls++) begin
      for (k = 0; k < FRAMES; k++) begin
        idx = (hand + k) % FRAMES;
        if (pt_dirty[idx] == cls[0] && pt_ref[idx] == cls[1]) begin
          found = 1;
          break;
        end
      end
    end
    for (k = hand; k != idx; k = (k + 1) % FRAMES) pt_ref[k] = 0;
    hand = (idx + 1) % FRAMES;
    return idx;
  endfunction

  function automatic resp_t predict_access(req_t rq);
    resp_t r;
    logic [19:0] pg;
    int i, v;
    bit known, ok, found, have;
    r = '0;
    pg = rq.addr[31:OFFSET_WIDTH];
    if (rq.act == ACT_TERM) begin
      for (i = 0; i < live_cnt; i++) begin
        if (live_pids[i] == rq.pid) begin
          for (; i + 1 < live_cnt; i++) live_pids[i] = live_pids[i+1];
          live_cnt--;
          break;
        end
      end
      for (i = 0; i < FRAMES; i++)
        if (pt_occ[i] && pt_proc[i] == rq.pid) pt_valid[i] = 0;
    end else begin
      ok = 1;
      found = 0;
      tally = tally + 16'd1;
      if (tally >= cur_decay) begin
        for (i = 0; i < FRAMES; i++) pt_freq[i] = pt_freq[i] >> 1;
        tally = '0;
      end
      known = 0;
      for (i = 0; i < live_cnt; i++) if (live_pids[i] == rq.pid) known = 1;
      if (known) begin
        for (i = 0; i < FRAMES; i++) begin
          if (pt_occ[i] && pt_proc[i] == rq.pid && pt_page[i] == pg) begin
            fill_frame(i, rq.pid, pg, rq.wr);
            r.granted = 1;
            r.hit = 1;
            r.frame = 6'(i);
            found = 1;
            break;
          end
        end
      end else if (live_cnt < PROCS) begin
        live_pids[live_cnt] = rq.pid;
        live_cnt++;
      end else begin
        ok = 0;
      end
      if (ok && !found) begin
        have = 1;
        v = 0;
        case (cur_policy)
          POL_CLOCK: v = clock_pick();
          POL_LFU: begin
            for (i = 1; i < FRAMES; i++) if (pt_freq[i] < pt_freq[v]) v = i;
            freq_bump(v);
          end
          POL_RANDOM: v = rq.pick;
          default: have = 0;
        endcase
        if (have) begin
          if (pt_dirty[v]) begin
            if (wr_faults != CNT_MAX) wr_faults++;
            r.kind = KIND_WRITE;
          end else begin
            if (rd_faults != CNT_MAX) rd_faults++;
            r.kind = KIND_READ;
          end
          fill_frame(v, rq.pid, pg, rq.wr);
          r.granted = 1;
          r.frame = 6'(v);
        end
      end
    end
    r.rd_total = rd_faults;
    r.wr_total = wr_faults;
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_POLICY) cur_policy = val[1:0];
    else cur_decay = val;
  endtask

  // caller sits just after a rising edge; valid stays high between back-to-back beats
  task automatic send_beat(req_t rq, bit typed, resp_t typed_r);
    resp_t r;
    @(negedge clk);
    if (idle_mode == 1 || idle_mode == 3) begin
      while ($urandom_range(99) < (idle_mode == 1 ? 80 : 36)) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tuser = rq.act;
    in_tdata = {1'b0, rq.pick, rq.wr, rq.addr, rq.pid};
    do @(posedge clk); while (!in_tready);
    r = predict_access(rq);
    if (typed) begin
      r.granted = typed_r.granted;
      r.hit = typed_r.hit;
      r.frame = typed_r.frame;
      r.kind = typed_r.kind;
    end
    pending_q.push_back(r);
    n_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (idle_mode == 2) out_tready <= ($urandom_range(99) >= 80);
    else if (idle_mode == 3) out_tready <= ($urandom_range(99) >= 36);
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    resp_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[73:0];
      if (pending_q.size() == 0) begin
        $error("result beat with nothing outstanding: %h", out_tdata);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (got.granted !== exp_r.granted) begin
          $error("granted exp %0d got %0d", exp_r.granted, got.granted); errors++;
        end
        if (got.hit !== exp_r.hit) begin
          $error("hit exp %0d got %0d", exp_r.hit, got.hit); errors++;
        end
        if (got.frame !== exp_r.frame) begin
          $error("frame exp %0d got %0d", exp_r.frame, got.frame); errors++;
        end
        if (got.kind !== exp_r.kind) begin
          $error("fault_kind exp %0d got %0d", exp_r.kind, got.kind); errors++;
        end
        if (got.rd_total !== exp_r.rd_total) begin
          $error("read_fault_total exp %0d got %0d", exp_r.rd_total, got.rd_total);
          errors++;
        end
        if (got.wr_total !== exp_r.wr_total) begin
          $error("write_fault_total exp %0d got %0d", exp_r.wr_total, got.wr_total);
          errors++;
        end
        if (exp_r.hit) n_hits++;
        else if (exp_r.kind != KIND_NONE) n_faults++;
        else n_denied++;
      end
    end
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d results outstanding", pending_q.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    row_t        dir_rows [$];
    row_t        rw;
    resp_t       tr;
    req_t        rq;
    logic [1:0]  pol_plan [8];
    logic [15:0] decay_plan [8];
    logic [19:0] pg;
    int          i, ph, n;

    pol_plan = '{POL_CLOCK, POL_LFU, POL_RANDOM, POL_LFU,
                 2'd3, POL_CLOCK, POL_LFU, POL_RANDOM};
    decay_plan = '{16'd1000, 16'd1, 16'hFFFF, 16'd0,
                   16'd5, 16'd7, 16'd50, 16'd3};

    for (i = 0; i < FRAMES; i++) begin
      pt_proc[i] = '0; pt_page[i] = '0; pt_occ[i] = 0; pt_valid[i] = 0;
      pt_dirty[i] = 0; pt_ref[i] = 0; pt_freq[i] = 16'd1;
    end
    live_cnt = 0; hand = 0; tally = '0; rd_faults = '0; wr_faults = '0;
    cur_policy = POL_CLOCK; cur_decay = DECAY_RESET;

    // act, pid, addr, wr, pick; typed granted, hit, frame, kind
    dir_rows.push_back('{'{ACT_ACCESS, 16'h0, 32'h0, 1'b0, 6'd0}, 1, 1, 0, 0, KIND_READ});
    dir_rows.push_back('{'{ACT_ACCESS, 16'h0, 32'h0, 1'b1, 6'd0}, 1, 1, 1, 0, KIND_NONE});
    dir_rows.push_back('{'{ACT_ACCESS, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 6'd63},
                         0, 0, 0, 0, KIND_NONE});
    dir_rows.push_back('{'{ACT_ACCESS, 16'hFFFF, 32'hFFFF_F000, 1'b0, 6'd63},
                         1, 1, 1, 1, KIND_NONE});
    dir_rows.push_back('{'{ACT_TERM, 16'h0, 32'h0, 1'b0, 6'd0}, 1, 0, 0, 0, KIND_NONE});
    // terminate of a process that never joined
    dir_rows.push_back('{'{ACT_TERM, 16'h1234, 32'h0, 1'b0, 6'd0}, 1, 0, 0, 0, KIND_NONE});
    // fill the active list, then one more is turned away
    for (i = 1; i <= 15; i++)
      dir_rows.push_back('{'{ACT_ACCESS, 16'(i), 32'(i) << 12, 1'(i % 2), 6'(i)},
                           0, 0, 0, 0, KIND_NONE});
    dir_rows.push_back('{'{ACT_ACCESS, 16'd100, 32'h5A5A_5A5A, 1'b1, 6'd1},
                         1, 0, 0, 0, KIND_NONE});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      rw = dir_rows[k];
      tr = '0;
      tr.granted = rw.granted; tr.hit = rw.hit; tr.frame = rw.frame; tr.kind = rw.kind;
      send_beat(rw.rq, rw.typed, tr);
    end
    drain();

    for (ph = 0; ph < 8; ph++) begin
      write_reg(REG_POLICY, {14'd0, pol_plan[ph]});
      write_reg(REG_DECAY, decay_plan[ph]);
      idle_mode = ph % 4;
      @(posedge clk);
      for (n = 0; n < 222; n++) begin
        rq.act = ($urandom_range(99) < 7) ? ACT_TERM : ACT_ACCESS;
        rq.pid = ($urandom_range(99) < 90) ? 16'($urandom_range(19)) : 16'($urandom);
        pg = ($urandom_range(99) < 80) ? 20'($urandom_range(11)) : 20'($urandom);
        rq.addr = {pg, 12'($urandom)};
        rq.wr = 1'($urandom_range(1));
        rq.pick = 6'($urandom_range(63));
        send_beat(rq, 0, '0);
        // hold off once per phase until everything has come back
        if (n == 111) begin
          @(negedge clk);
          in_tvalid = 1'b0;
          while (pending_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("%0d beats over 8 policy/decay settings and 4 idling patterns", n_items);
    $display("%0d hits, %0d faults, %0d denied or terminate", n_hits, n_faults, n_denied);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[inverted_page_table_replacer_unit.f]
rtl/ipt_pkg.sv
rtl/ipt_ram.sv
rtl/inverted_page_table_replacer_unit.sv
dv/tb_inverted_page_table_replacer_unit.sv
